// ===== rtl/core/tlg_pkg.sv =====
// tlg_pkg: shared constants, types and helpers for the toroidal life grid.
// No dependencies; used by every module in rtl/core.
`default_nettype none

package tlg_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;

    localparam int CFG_W     = 7;
    localparam int CMD_W     = 2;
    localparam int COORD_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int COL_IDX_W = $clog2(MAX_COLS);
    localparam int STEP_W    = $clog2(2 * MAX_ROWS);

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET_DIM   = 7'd30;

    // live-neighbor counts of the rule
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_GEN,
        ST_DELIVER
    } t_state;

    // broadcast from the controller to every column cell
    typedef struct packed {
        logic                 shift;    // rotate the active rows by one
        logic                 first;    // first rotation of a generation
        logic                 compute;  // head row takes its next-generation value
        logic                 last;     // head row is row 0, down neighbor from capture
        logic                 wr_en;    // head row is the addressed row of a write
        logic                 wr_bit;
        logic [ROW_CNT_W-1:0] rows;     // effective active height
    } t_cell_ctl;

    // zero counts as one, larger than the array saturates
    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned maxv);
        int unsigned r;
        if (v == '0) begin
            r = 1;
        end else if (int'(v) > maxv) begin
            r = maxv;
        end else begin
            r = int'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tlg_cell.sv =====
// tlg_cell: one grid column as a rotating shift line of cells plus the life rule.
// Depends on tlg_pkg; exchanges a three-row window with both neighbor columns.
`default_nettype none

module tlg_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tlg_pkg::t_cell_ctl  i_ctl,
    input  wire logic                i_active,
    input  wire logic                i_wr_sel,
    input  wire logic [2:0]          i_left_win,
    input  wire logic [2:0]          i_right_win,
    output logic [2:0]               o_win,
    output logic                     o_head
);

    logic [tlg_pkg::MAX_ROWS-1:0] r_line;
    logic [tlg_pkg::MAX_ROWS-1:0] n_line;
    logic [tlg_pkg::MAX_ROWS-1:0] w_shifted;
    logic                         r_prev;
    logic                         r_row1;
    logic                         w_down;
    logic [3:0]                   w_count;
    logic                         w_alive;
    logic                         w_new_head;

    // r_prev holds the old value of the row above the head
    assign w_down = i_ctl.last ? r_row1 : r_line[1];
    assign o_win  = {r_prev, r_line[0], w_down};
    assign o_head = r_line[0];

    assign w_count = {3'b000, i_left_win[2]} + {3'b000, i_left_win[1]}
                   + {3'b000, i_left_win[0]} + {3'b000, i_right_win[2]}
                   + {3'b000, i_right_win[1]} + {3'b000, i_right_win[0]}
                   + {3'b000, r_prev} + {3'b000, w_down};

    assign w_alive = (w_count == tlg_pkg::BIRTH_COUNT)
                  || ((w_count == tlg_pkg::SURVIVE_COUNT) && r_line[0]);

    always_comb begin
        priority if (i_ctl.compute && i_active) begin
            w_new_head = w_alive;
        end else if (i_ctl.wr_en && i_wr_sel) begin
            w_new_head = i_ctl.wr_bit;
        end else begin
            w_new_head = r_line[0];
        end
    end

    assign w_shifted = {1'b0, r_line[tlg_pkg::MAX_ROWS-1:1]};

    // rows at or beyond the active height keep their values
    always_comb begin
        for (int i = 0; i < tlg_pkg::MAX_ROWS; i++) begin
            if (i + 1 < int'(i_ctl.rows)) begin
                n_line[i] = w_shifted[i];
            end else if (i + 1 == int'(i_ctl.rows)) begin
                n_line[i] = w_new_head;
            end else begin
                n_line[i] = r_line[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
            r_prev <= 1'b0;
            r_row1 <= 1'b0;
        end else if (i_ctl.shift) begin
            r_line <= n_line;
            r_prev <= r_line[0];
            if (i_ctl.first) begin
                r_row1 <= (i_ctl.rows == tlg_pkg::ROW_CNT_W'(1)) ? r_line[0] : r_line[1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tlg_ctrl.sv =====
// tlg_ctrl: configuration registers, command sequencer and result register.
// Depends on tlg_pkg; drives the broadcast control of the column cells.
`default_nettype none

module tlg_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tlg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tlg_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [tlg_pkg::CMD_W-1:0]        i_cmd,
    input  wire logic [tlg_pkg::COORD_W-1:0]      i_col,
    input  wire logic [tlg_pkg::COORD_W-1:0]      i_row,
    input  wire logic                             i_cell_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_cell_alive,
    output tlg_pkg::t_cell_ctl                    o_ctl,
    output logic [tlg_pkg::COORD_W-1:0]           o_col,
    output logic [tlg_pkg::COL_CNT_W-1:0]         o_cols,
    input  wire logic                             i_head_bit
);

    tlg_pkg::t_state                 r_state;
    tlg_pkg::t_state                 n_state;
    logic [tlg_pkg::CFG_W-1:0]       r_width;
    logic [tlg_pkg::CFG_W-1:0]       r_height;
    logic [tlg_pkg::STEP_W-1:0]      r_step;
    logic [tlg_pkg::STEP_W-1:0]      n_step;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic                            r_out_cell;
    logic                            r_is_read;
    logic [tlg_pkg::COORD_W-1:0]     r_row;
    logic [tlg_pkg::COORD_W-1:0]     r_col;
    logic                            r_wbit;
    logic                            r_rdata;

    logic [tlg_pkg::COL_CNT_W-1:0]   w_cols;
    logic [tlg_pkg::ROW_CNT_W-1:0]   w_rows;
    logic                            w_in_acc;
    logic                            w_inside;
    logic                            w_out_free;
    logic                            w_at_row;
    logic                            w_shift;

    assign w_cols = tlg_pkg::COL_CNT_W'(tlg_pkg::clamp_dim(r_width,  tlg_pkg::MAX_COLS));
    assign w_rows = tlg_pkg::ROW_CNT_W'(tlg_pkg::clamp_dim(r_height, tlg_pkg::MAX_ROWS));

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_inside   = (int'(i_col) < int'(w_cols)) && (int'(i_row) < int'(w_rows));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_at_row   = int'(r_step) == int'(r_row);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlg_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (tlg_pkg::t_cmd'(i_cmd))
                        tlg_pkg::CMD_WRITE:
                            n_state = w_inside ? tlg_pkg::ST_ACCESS : tlg_pkg::ST_IDLE;
                        tlg_pkg::CMD_READ:
                            n_state = w_inside ? tlg_pkg::ST_ACCESS : tlg_pkg::ST_DELIVER;
                        tlg_pkg::CMD_STEP:
                            n_state = tlg_pkg::ST_GEN;
                        default:
                            n_state = tlg_pkg::ST_IDLE;
                    endcase
                end
            end
            tlg_pkg::ST_ACCESS: begin
                if (int'(r_step) == int'(w_rows) - 1) begin
                    n_state = r_is_read ? tlg_pkg::ST_DELIVER : tlg_pkg::ST_IDLE;
                end
            end
            tlg_pkg::ST_GEN: begin
                if (int'(r_step) == 2 * int'(w_rows) - 1) begin
                    n_state = tlg_pkg::ST_IDLE;
                end
            end
            tlg_pkg::ST_DELIVER: begin
                if (w_out_free) begin
                    n_state = tlg_pkg::ST_IDLE;
                end
            end
            default: n_state = tlg_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall    = (r_state != tlg_pkg::ST_IDLE);
        w_shift       = (r_state == tlg_pkg::ST_ACCESS) || (r_state == tlg_pkg::ST_GEN);
        o_ctl.shift   = w_shift;
        o_ctl.first   = (r_state == tlg_pkg::ST_GEN) && (r_step == '0);
        o_ctl.compute = (r_state == tlg_pkg::ST_GEN) && (r_step != '0)
                     && (int'(r_step) <= int'(w_rows));
        o_ctl.last    = (r_state == tlg_pkg::ST_GEN) && (int'(r_step) == int'(w_rows));
        o_ctl.wr_en   = (r_state == tlg_pkg::ST_ACCESS) && !r_is_read && w_at_row;
        o_ctl.wr_bit  = r_wbit;
        o_ctl.rows    = w_rows;
    end

    assign n_step = ((r_state == n_state) && w_shift) ? r_step + 1'b1 : '0;

    assign n_out_valid = ((r_state == tlg_pkg::ST_DELIVER) && w_out_free)
                       ? 1'b1 : (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlg_pkg::ST_IDLE;
            r_width     <= tlg_pkg::CFG_RESET_DIM;
            r_height    <= tlg_pkg::CFG_RESET_DIM;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == tlg_pkg::REG_GRID_WIDTH) begin
                    r_width <= i_cfg_data;
                end else if (i_cfg_index == tlg_pkg::REG_GRID_HEIGHT) begin
                    r_height <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_is_read <= (i_cmd == tlg_pkg::CMD_READ);
            r_row     <= i_row;
            r_col     <= i_col;
            r_wbit    <= i_cell_in;
            r_rdata   <= 1'b0;   // a read outside the active area returns dead
        end else if ((r_state == tlg_pkg::ST_ACCESS) && r_is_read && w_at_row) begin
            r_rdata <= i_head_bit;
        end
        if ((r_state == tlg_pkg::ST_DELIVER) && w_out_free) begin
            r_out_cell <= r_rdata;
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_cell_alive = r_out_cell;
    assign o_col        = r_col;
    assign o_cols       = w_cols;

endmodule

`default_nettype wire

// ===== rtl/core/toroidal_life_grid_step.sv =====
// toroidal_life_grid_step: toroidal life grid, a chain of column cells under one sequencer.
// Depends on tlg_pkg, tlg_ctrl and tlg_cell.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | to block  | i_in_valid / o_in_stall| i_cmd, i_col, i_row, i_cell_in
//  out     | from block| o_out_valid/ i_out_stall| o_cell_alive
//  cfg     | to block  | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// Between accepted transactions: a write inside the area makes one full rotation of the
// active rows, a read inside the rotation plus a result load, a read outside only the
// result load, an outside write or unused command none, and a generation a first rotation,
// then rotations that update each row, then rotations that realign them. A read result
// is registered in delivery. Reset clears every cell and sets width and height to 30.
// A result waiting under stall keeps a later read in delivery, with the input stalled.
`default_nettype none

module toroidal_life_grid_step (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tlg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tlg_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [tlg_pkg::CMD_W-1:0]        i_cmd,
    input  wire logic [tlg_pkg::COORD_W-1:0]      i_col,
    input  wire logic [tlg_pkg::COORD_W-1:0]      i_row,
    input  wire logic                             i_cell_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_cell_alive
);

    tlg_pkg::t_cell_ctl                  w_ctl;
    logic [tlg_pkg::COORD_W-1:0]         w_col;
    logic [tlg_pkg::COL_CNT_W-1:0]       w_cols;
    logic [tlg_pkg::COL_IDX_W-1:0]       w_last_col;
    logic [2:0]                          w_wins [tlg_pkg::MAX_COLS];
    logic [tlg_pkg::MAX_COLS-1:0]        w_heads;
    logic                                w_head_bit;

    assign w_last_col = tlg_pkg::COL_IDX_W'(w_cols - 1'b1);
    assign w_head_bit = w_heads[tlg_pkg::COL_IDX_W'(w_col)];

    tlg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_cell_in    (i_cell_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_alive (o_cell_alive),
        .o_ctl        (w_ctl),
        .o_col        (w_col),
        .o_cols       (w_cols),
        .i_head_bit   (w_head_bit)
    );

    for (genvar x = 0; x < tlg_pkg::MAX_COLS; x++) begin : g_col
        logic [2:0] w_left;
        logic [2:0] w_right;

        // horizontal wrap at the active width
        if (x == 0) begin : g_left_wrap
            assign w_left = w_wins[w_last_col];
        end else begin : g_left
            assign w_left = w_wins[x-1];
        end

        if (x == tlg_pkg::MAX_COLS - 1) begin : g_right_wrap
            assign w_right = w_wins[0];
        end else begin : g_right
            assign w_right = (w_last_col == tlg_pkg::COL_IDX_W'(x)) ? w_wins[0] : w_wins[x+1];
        end

        tlg_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_active    (x < int'(w_cols)),
            .i_wr_sel    (int'(w_col) == x),
            .i_left_win  (w_left),
            .i_right_win (w_right),
            .o_win       (w_wins[x]),
            .o_head      (w_heads[x])
        );
    end

endmodule

`default_nettype wire

// ===== rtl/core/tlg_checker.sv =====
// tlg_checker: port-level checks of the life grid over time, bound to the top level.
// Depends on tlg_pkg; sees the ports of toroidal_life_grid_step only.
`default_nettype none

module tlg_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             o_in_stall,
    input wire logic [tlg_pkg::CMD_W-1:0]        i_cmd,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_stall,
    input wire logic                             o_cell_alive
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cell_alive))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_no_result_for_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_cmd != tlg_pkg::CMD_READ) |=> !$rose(o_out_valid))
        else $error("result raised by a non-read transaction");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_cmd == tlg_pkg::CMD_READ) |=> o_in_stall)
        else $error("new transaction taken while a read is pending");

endmodule

bind toroidal_life_grid_step tlg_checker u_tlg_checker (.*);

`default_nettype wire
